// ===== rtl/pbms_pkg.sv =====
// Shared types and constants for the pump budget and moisture statistics block.
package pbms_pkg;

  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_ON      = 3'd1;
  localparam logic [2:0] ACT_OFF     = 3'd2;
  localparam logic [2:0] ACT_PULSE   = 3'd3;
  localparam logic [2:0] ACT_SAMPLE  = 3'd4;
  localparam logic [2:0] ACT_REFILL  = 3'd5;
  localparam logic [2:0] ACT_NEWDAY  = 3'd6;

  localparam logic [1:0] REG_PULSE_LEN = 2'd0;
  localparam logic [1:0] REG_CAPACITY  = 2'd1;
  localparam logic [1:0] REG_DRY       = 2'd2;
  localparam logic [1:0] REG_SAT       = 2'd3;

  localparam int DIV_N_W = 48;
  localparam int DIV_D_W = 32;

  localparam logic signed [47:0] SUM_LIMIT = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [31:0] MIN_INIT  = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] pulse_override_ms;
    logic [11:0] raw_reading;
  } in_t;

  typedef struct packed {
    logic               pump_running;
    logic               timeout_flag;
    logic               auto_stopped;
    logic [15:0]        run_count;
    logic [31:0]        total_run_ms;
    logic signed [19:0] last_percent;
    logic signed [19:0] average_percent;
    logic signed [31:0] lowest_percent;
    logic signed [19:0] highest_percent;
    logic [15:0]        day_pump_starts;
    logic [31:0]        day_run_ms;
    logic               calibration_error;
  } out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic map_start;
    logic log_pct;
    logic avg_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic map_item;
    logic div_done;
  } stat_t;

endpackage

// ===== rtl/pbms_div.sv =====
// Shared serial unsigned divider, one quotient bit per cycle.
module pbms_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pbms_pkg::DIV_N_W-1:0]  dividend,
  input  logic [pbms_pkg::DIV_D_W-1:0]  divisor,
  output logic [pbms_pkg::DIV_N_W-1:0]  quotient,
  output logic                          done
);
  localparam int CW = $clog2(pbms_pkg::DIV_N_W + 1);

  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [pbms_pkg::DIV_D_W-1:0]  rem_r, rem_nxt;
  logic [pbms_pkg::DIV_D_W-1:0]  den_r, den_nxt;
  logic [pbms_pkg::DIV_N_W-1:0]  quo_r, quo_nxt;
  logic                          done_r, done_nxt;
  logic [pbms_pkg::DIV_D_W:0]    trial;

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[pbms_pkg::DIV_N_W-1]};
    if (start) begin
      cnt_nxt = CW'(pbms_pkg::DIV_N_W);
      rem_nxt = '0;
      den_nxt = divisor;
      quo_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = pbms_pkg::DIV_D_W'(trial - {1'b0, den_r});
        quo_nxt = {quo_r[pbms_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[pbms_pkg::DIV_D_W-1:0];
        quo_nxt = {quo_r[pbms_pkg::DIV_N_W-2:0], 1'b0};
      end
      if (cnt_r == CW'(1)) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

// ===== rtl/pbms_dp.sv =====
// Datapath: config, pump budget state, day statistics and result register.
module pbms_dp #(
  parameter int SENSOR_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_idx,
  input  logic [31:0]       cfg_wdata,
  input  pbms_pkg::in_t     in_data,
  input  pbms_pkg::cmd_t    cmd,
  output pbms_pkg::stat_t   stat,
  output pbms_pkg::out_t    out_data
);
  localparam logic [11:0] SMASK = (SENSOR_BITS >= 12) ? 12'hFFF :
                                  12'((1 << SENSOR_BITS) - 1);
  localparam logic [COUNT_BITS-1:0] CMAX = '1;

  // config
  logic [31:0] pulse_len_r, cap_r;
  logic [11:0] dry_r, sat_r;

  // item and pump state
  pbms_pkg::in_t in_r;
  logic                  pump_r, pump_nxt;
  logic                  tmo_r, tmo_nxt;
  logic [31:0]           cur_r, cur_nxt;
  logic                  pact_r, pact_nxt;
  logic [31:0]           prem_r, prem_nxt;
  logic [COUNT_BITS-1:0] runs_r, runs_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] starts_r, starts_nxt;
  logic [31:0]           dayms_r, dayms_nxt;
  logic                  astop_r, astop_nxt;

  // statistics
  logic signed [19:0] last_r;
  logic signed [47:0] sum_r;
  logic [31:0]        cnt_r;
  logic signed [31:0] min_r;
  logic signed [19:0] max_r;
  logic               bad_r, neg_r;

  // divider
  logic [pbms_pkg::DIV_N_W-1:0] div_n, div_q;
  logic [pbms_pkg::DIV_D_W-1:0] div_d;
  logic                         div_done;

  // mapping operands
  logic [11:0]        x_m, dry_m, sat_m;
  logic signed [12:0] diff, den;
  logic signed [19:0] num;
  logic [19:0]        num_mag;
  logic [12:0]        den_mag;
  logic [47:0]        sum_mag;
  logic signed [19:0] pct;
  logic signed [48:0] sum_ext;
  logic signed [19:0] avg;

  assign x_m   = in_r.raw_reading & SMASK;
  assign dry_m = dry_r & SMASK;
  assign sat_m = sat_r & SMASK;
  assign diff  = $signed({1'b0, x_m}) - $signed({1'b0, dry_m});
  assign den   = $signed({1'b0, sat_m}) - $signed({1'b0, dry_m});
  assign num   = 20'(diff * 13'sd100);
  assign num_mag = num[19] ? 20'(-num) : 20'(num);
  assign den_mag = den[12] ? 13'(-den) : 13'(den);
  assign sum_mag = sum_r[47] ? 48'(-sum_r) : 48'(sum_r);

  assign div_n = cmd.map_start ? pbms_pkg::DIV_N_W'(num_mag) : sum_mag;
  assign div_d = cmd.map_start ? pbms_pkg::DIV_D_W'(den_mag) : cnt_r;

  pbms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.map_start | cmd.avg_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quotient (div_q),
    .done     (div_done)
  );

  assign pct = bad_r ? 20'sd0 : (neg_r ? -$signed(div_q[19:0]) : $signed(div_q[19:0]));
  assign sum_ext = 49'(sum_r) + 49'(pct);
  assign avg = (cnt_r == '0) ? 20'sd0 :
               (sum_r[47] ? -$signed(div_q[19:0]) : $signed(div_q[19:0]));

  assign stat.map_item = (in_r.action == pbms_pkg::ACT_SAMPLE) ||
                         (in_r.action == pbms_pkg::ACT_NEWDAY);
  assign stat.div_done = div_done;

  // pump actions then budget check, settled combinationally
  always_comb begin
    logic [31:0] p;
    logic [32:0] psum;
    logic [31:0] prem_dec;
    logic        do_stop;
    p          = (in_r.pulse_override_ms != '0) ? in_r.pulse_override_ms : pulse_len_r;
    psum       = {1'b0, p} + {1'b0, acc_r};
    prem_dec   = 32'(prem_r - 1'b1);
    do_stop    = 1'b0;
    pump_nxt   = pump_r;
    tmo_nxt    = tmo_r;
    cur_nxt    = cur_r;
    pact_nxt   = pact_r;
    prem_nxt   = prem_r;
    runs_nxt   = runs_r;
    acc_nxt    = acc_r;
    starts_nxt = starts_r;
    dayms_nxt  = dayms_r;
    astop_nxt  = 1'b0;

    if (in_r.action == pbms_pkg::ACT_NEWDAY) begin
      starts_nxt = '0;
      dayms_nxt  = '0;
    end

    case (in_r.action)
      pbms_pkg::ACT_TICK: begin
        if (pump_r) begin
          cur_nxt = (cur_r == '1) ? cur_r : cur_r + 1'b1;
          if (pact_r) begin
            if (prem_r != '0) prem_nxt = prem_dec;
            if (prem_r <= 32'd1) do_stop = 1'b1;
          end
        end
      end
      pbms_pkg::ACT_ON: begin
        if (!pump_r && !tmo_r) begin
          pump_nxt = 1'b1;
          cur_nxt  = '0;
        end
      end
      pbms_pkg::ACT_OFF: do_stop = 1'b1;
      pbms_pkg::ACT_PULSE: begin
        if (psum >= {1'b0, cap_r}) tmo_nxt = 1'b1;
        if (!tmo_nxt) begin
          if (!pump_r) begin
            pump_nxt = 1'b1;
            cur_nxt  = '0;
          end
          if (p == '0) begin
            do_stop = 1'b1;
          end else begin
            pact_nxt = 1'b1;
            prem_nxt = p;
          end
        end
      end
      pbms_pkg::ACT_REFILL: do_stop = 1'b1;
      default: ;
    endcase

    // budget check sees the run after the action; a stop leaves the pump off
    if (!do_stop && pump_nxt && ({1'b0, cur_nxt} + {1'b0, acc_r} >= {1'b0, cap_r})) begin
      do_stop   = 1'b1;
      tmo_nxt   = 1'b1;
      astop_nxt = 1'b1;
    end

    if (do_stop) begin
      if (pump_nxt) begin
        runs_nxt   = (runs_r == CMAX) ? runs_r : runs_r + 1'b1;
        starts_nxt = (starts_nxt == CMAX) ? starts_nxt : starts_nxt + 1'b1;
        dayms_nxt  = ({1'b0, dayms_nxt} + {1'b0, cur_nxt} > 33'hFFFF_FFFF) ? '1 :
                     dayms_nxt + cur_nxt;
        acc_nxt    = ({1'b0, acc_r} + {1'b0, cur_nxt} > 33'hFFFF_FFFF) ? '1 :
                     acc_r + cur_nxt;
      end
      pump_nxt = 1'b0;
      pact_nxt = 1'b0;
      prem_nxt = '0;
      cur_nxt  = '0;
    end

    if (in_r.action == pbms_pkg::ACT_REFILL) begin
      runs_nxt = '0;
      acc_nxt  = '0;
      tmo_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_len_r <= 32'd1000;
      cap_r       <= 32'd60000;
      dry_r       <= 12'd3000;
      sat_r       <= 12'd1200;
      pump_r      <= 1'b0;
      tmo_r       <= 1'b0;
      cur_r       <= '0;
      pact_r      <= 1'b0;
      prem_r      <= '0;
      runs_r      <= '0;
      acc_r       <= '0;
      starts_r    <= '0;
      dayms_r     <= '0;
      astop_r     <= 1'b0;
      last_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      min_r       <= pbms_pkg::MIN_INIT;
      max_r       <= '0;
      bad_r       <= 1'b0;
      neg_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          pbms_pkg::REG_PULSE_LEN: pulse_len_r <= cfg_wdata;
          pbms_pkg::REG_CAPACITY:  cap_r       <= cfg_wdata;
          pbms_pkg::REG_DRY:       dry_r       <= cfg_wdata[11:0];
          pbms_pkg::REG_SAT:       sat_r       <= cfg_wdata[11:0];
          default: ;
        endcase
      end
      if (cmd.exec) begin
        pump_r   <= pump_nxt;
        tmo_r    <= tmo_nxt;
        cur_r    <= cur_nxt;
        pact_r   <= pact_nxt;
        prem_r   <= prem_nxt;
        runs_r   <= runs_nxt;
        acc_r    <= acc_nxt;
        starts_r <= starts_nxt;
        dayms_r  <= dayms_nxt;
        astop_r  <= astop_nxt;
        // flag only on beats that map a reading
        bad_r    <= stat.map_item & (dry_m == sat_m);
        if (in_r.action == pbms_pkg::ACT_NEWDAY) begin
          last_r <= '0;
          sum_r  <= '0;
          cnt_r  <= '0;
          min_r  <= pbms_pkg::MIN_INIT;
          max_r  <= '0;
        end
      end
      if (cmd.map_start) begin
        neg_r <= num[19] ^ den[12];
      end
      if (cmd.log_pct) begin
        last_r <= pct;
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + 1'b1;
          if (sum_ext > 49'(pbms_pkg::SUM_LIMIT))       sum_r <= pbms_pkg::SUM_LIMIT;
          else if (sum_ext < -49'(pbms_pkg::SUM_LIMIT)) sum_r <= -pbms_pkg::SUM_LIMIT;
          else                                          sum_r <= 48'(sum_ext);
        end
        if (32'(pct) < min_r) min_r <= 32'(pct);
        if (pct > max_r)      max_r <= pct;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) in_r <= in_data;
    if (cmd.load_out) begin
      out_data.pump_running      <= pump_r;
      out_data.timeout_flag      <= tmo_r;
      out_data.auto_stopped      <= astop_r;
      out_data.run_count         <= 16'(runs_r);
      out_data.total_run_ms      <= acc_r;
      out_data.last_percent      <= last_r;
      out_data.average_percent   <= avg;
      out_data.lowest_percent    <= min_r;
      out_data.highest_percent   <= max_r;
      out_data.day_pump_starts   <= 16'(starts_r);
      out_data.day_run_ms        <= dayms_r;
      out_data.calibration_error <= bad_r;
    end
  end
endmodule

// ===== rtl/pbms_ctrl.sv =====
// Sequencer: steps one item through pump update, mapping and logging (readings only) and average.
module pbms_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  pbms_pkg::stat_t  stat,
  output pbms_pkg::cmd_t   cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MAP  = 3'd2;
  localparam logic [2:0] S_LOG  = 3'd3;
  localparam logic [2:0] S_AVG  = 3'd4;
  localparam logic [2:0] S_WAVG = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r & ~out_ready;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.map_item) begin
          cmd.map_start = 1'b1;
          state_nxt     = S_MAP;
        end else begin
          state_nxt = S_AVG;
        end
      end
      S_MAP:  if (stat.div_done) state_nxt = S_LOG;
      S_LOG: begin
        cmd.log_pct = 1'b1;
        state_nxt   = S_AVG;
      end
      S_AVG: begin
        cmd.avg_start = 1'b1;
        state_nxt     = S_WAVG;
      end
      S_WAVG: if (stat.div_done) state_nxt = S_FIN;
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          ov_nxt       = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule

// ===== rtl/pump_budget_and_moisture_stats.sv =====
// Top level: pump run-time budget keeper with soil-moisture day statistics.
//
//  channel | signals                       | beat taken when
//  --------+-------------------------------+---------------------------
//  in      | in_valid, in_ready, in_data   | in_valid & in_ready
//  out     | out_valid, out_ready, out_data| out_valid & out_ready
//  cfg     | cfg_we, cfg_idx, cfg_wdata    | cfg_we
//
//  Sequence: each input beat uses the 48-step serial divider, once for the
//  percent map on sample and new day beats and once for the day average
//  on every beat; the next input beat is taken only back in idle, after
//  the result is loaded.
//  Reset: synchronous, active low; control, config and state registers return to their defaults.
//  Stalls: the result register holds a finished beat while the next input
//  beat is taken and worked; only the final load waits on out_ready.
module pump_budget_and_moisture_stats #(
  parameter int SENSOR_BITS = 12,
  parameter int COUNT_BITS  = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pbms_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pbms_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [31:0]     cfg_wdata
);
  pbms_pkg::cmd_t  cmd;
  pbms_pkg::stat_t stat;

  // sequencer: one beat in flight
  pbms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // pump state, statistics, shared divider and result register
  pbms_dp #(
    .SENSOR_BITS (SENSOR_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );
endmodule

// ===== rtl/pbms_chk.sv =====
// Port-level checker for the pump budget block, bound to the top level.
module pbms_chk (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pbms_pkg::out_t  out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while one is in work");

  a_astop_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.auto_stopped |-> !out_data.pump_running)
    else $error("auto stop left the pump running");

  a_astop_tmo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.auto_stopped |-> out_data.timeout_flag)
    else $error("auto stop without timeout");
endmodule

bind pump_budget_and_moisture_stats pbms_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/pump_budget_and_moisture_stats_test.sv =====
// Self-checking testbench for the pump budget and moisture statistics block.
`timescale 1ns / 100ps

module pump_budget_and_moisture_stats_test;

  localparam int IDLE_LIMIT = 6000;  // cycles with no beat and no write

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  pbms_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  pbms_pkg::out_t out_data;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_idx = pbms_pkg::REG_PULSE_LEN;
  logic [31:0]    cfg_wdata = '0;

  pump_budget_and_moisture_stats u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---- shadow copy of the registers and the state ----
  logic [31:0] m_pulse_len, m_capacity;
  logic [11:0] m_dry, m_sat;
  logic        s_pump, s_tmo, s_pulse_on;
  logic [31:0] s_cur_run, s_pulse_left, s_acc_ms, s_day_ms;
  int unsigned s_runs, s_starts;
  int          s_last, s_min, s_max;
  longint      s_sum, s_cnt;

  pbms_pkg::in_t  pending_beats[$];   // items waiting for the driver
  pbms_pkg::out_t expected_status[$]; // predicted result beats, oldest first
  int     errors = 0;
  int     gap = 0;
  int     stall = 0;
  int     idle_cycles = 0;
  int     n_results = 0;
  int     n_items = 0;
  bit     no_idle = 1'b0;
  logic   taken;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int unsigned bump(int unsigned c);
    return (c >= 65535) ? 65535 : c + 1;
  endfunction

  function automatic void pump_stop();
    if (s_pump) begin
      s_runs   = bump(s_runs);
      s_starts = bump(s_starts);
      s_day_ms = add_sat(s_day_ms, s_cur_run);
      s_acc_ms = add_sat(s_acc_ms, s_cur_run);
    end
    s_pump = 1'b0;
    s_pulse_on = 1'b0;
    s_pulse_left = '0;
    s_cur_run = '0;
  endfunction

  function automatic void pump_start();
    if (!s_pump && !s_tmo) begin
      s_pump = 1'b1;
      s_cur_run = '0;
    end
  endfunction

  function automatic void day_clear();
    s_last = 0; s_sum = 0; s_cnt = 0;
    s_min = 32'sh7FFF_FFFF; s_max = 0;
    s_starts = 0; s_day_ms = '0;
  endfunction

  // maps a reading into the day stats; 1 when dry equals saturated
  function automatic logic log_moisture(logic [11:0] raw);
    longint d, s, x;
    int     pct;
    d = m_dry; s = m_sat; x = raw;
    pct = 0;
    if (d != s) pct = int'(((x - d) * 100) / (s - d));
    s_last = pct;
    if (s_cnt < 64'h0_FFFF_FFFF) begin
      s_cnt++;
      s_sum += pct;
      if (s_sum > 64'sh7FFF_FFFF_FFFF) s_sum = 64'sh7FFF_FFFF_FFFF;
      if (s_sum < -64'sh7FFF_FFFF_FFFF) s_sum = -64'sh7FFF_FFFF_FFFF;
    end
    if (pct < s_min) s_min = pct;
    if (pct > s_max) s_max = pct;
    return d == s;
  endfunction

  function automatic void status_reset();
    m_pulse_len = 32'd1000; m_capacity = 32'd60000;
    m_dry = 12'd3000; m_sat = 12'd1200;
    s_pump = 0; s_tmo = 0; s_cur_run = 0; s_pulse_on = 0; s_pulse_left = 0;
    s_runs = 0; s_acc_ms = 0;
    day_clear();
  endfunction

  function automatic pbms_pkg::out_t pump_status_after(pbms_pkg::in_t it);
    pbms_pkg::out_t o;
    logic           cal, auto;
    logic [31:0]    p;
    longint         avg;
    cal = 0; auto = 0; avg = 0;
    case (it.action)
      pbms_pkg::ACT_TICK: begin
        if (s_pump) begin
          s_cur_run = add_sat(s_cur_run, 1);
          if (s_pulse_on) begin
            if (s_pulse_left > 0) s_pulse_left--;
            if (s_pulse_left == 0) pump_stop();
          end
        end
      end
      pbms_pkg::ACT_ON:  pump_start();
      pbms_pkg::ACT_OFF: pump_stop();
      pbms_pkg::ACT_PULSE: begin
        p = (it.pulse_override_ms != 0) ? it.pulse_override_ms : m_pulse_len;
        if ({32'd0, p} + {32'd0, s_acc_ms} >= {32'd0, m_capacity}) s_tmo = 1;
        if (!s_tmo) begin
          pump_start();
          if (p == 0) pump_stop();
          else begin
            s_pulse_on = 1;
            s_pulse_left = p;
          end
        end
      end
      pbms_pkg::ACT_SAMPLE: cal = log_moisture(it.raw_reading);
      pbms_pkg::ACT_REFILL: begin
        pump_stop();
        s_runs = 0; s_acc_ms = 0; s_tmo = 0;
      end
      pbms_pkg::ACT_NEWDAY: begin
        day_clear();
        cal = log_moisture(it.raw_reading);
      end
      default: ;
    endcase
    // budget check closes every beat
    if (s_pump && ({32'd0, s_cur_run} + {32'd0, s_acc_ms} >= {32'd0, m_capacity})) begin
      pump_stop();
      s_tmo = 1;
      auto = 1;
    end
    if (s_cnt != 0) avg = s_sum / s_cnt;
    o.pump_running      = s_pump;
    o.timeout_flag      = s_tmo;
    o.auto_stopped      = auto;
    o.run_count         = s_runs[15:0];
    o.total_run_ms      = s_acc_ms;
    o.last_percent      = s_last[19:0];
    o.average_percent   = avg[19:0];
    o.lowest_percent    = s_min;
    o.highest_percent   = s_max[19:0];
    o.day_pump_starts   = s_starts[15:0];
    o.day_run_ms        = s_day_ms;
    o.calibration_error = cal;
    return o;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // ---- driver: feeds in beats from the pending queue ----
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap = 0;
    end else begin
      taken = in_valid && in_ready;
      if (taken) begin
        expected_status.push_back(pump_status_after(in_data));
        n_items++;
        gap = pick_gap();
      end
      if (!in_valid || taken) begin
        if (gap == 0 && pending_beats.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
          if (gap > 0) gap--;
        end
      end
    end
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      errors++;
    end
  endtask

  // ---- monitor: result beats against predictions; back-pressure; watchdog ----
  always @(posedge clk) begin
    pbms_pkg::out_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_status.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected_status.pop_front();
          check_field("pump_running", e.pump_running, out_data.pump_running);
          check_field("timeout_flag", e.timeout_flag, out_data.timeout_flag);
          check_field("auto_stopped", e.auto_stopped, out_data.auto_stopped);
          check_field("run_count", e.run_count, out_data.run_count);
          check_field("total_run_ms", e.total_run_ms, out_data.total_run_ms);
          check_field("last_percent", e.last_percent, out_data.last_percent);
          check_field("average_percent", e.average_percent, out_data.average_percent);
          check_field("lowest_percent", e.lowest_percent, out_data.lowest_percent);
          check_field("highest_percent", e.highest_percent, out_data.highest_percent);
          check_field("day_pump_starts", e.day_pump_starts, out_data.day_pump_starts);
          check_field("day_run_ms", e.day_run_ms, out_data.day_run_ms);
          check_field("calibration_error", e.calibration_error,
                      out_data.calibration_error);
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
      // receiver stalls: mostly ready, some short and a few long stalls
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 20) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 70)
                                             : $urandom_range(0, 3);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---- stimulus ----
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    case (idx)
      pbms_pkg::REG_PULSE_LEN: m_pulse_len = val;
      pbms_pkg::REG_CAPACITY:  m_capacity  = val;
      pbms_pkg::REG_DRY:       m_dry       = val[11:0];
      default:                 m_sat       = val[11:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [31:0] plen, logic [31:0] cap,
                           logic [31:0] dry, logic [31:0] sat);
    write_reg(pbms_pkg::REG_PULSE_LEN, plen);
    write_reg(pbms_pkg::REG_CAPACITY, cap);
    write_reg(pbms_pkg::REG_DRY, dry);
    write_reg(pbms_pkg::REG_SAT, sat);
  endtask

  task automatic drain();
    wait (pending_beats.size() == 0 && !in_valid && expected_status.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic push(logic [2:0] act, logic [31:0] ovr, logic [11:0] raw);
    pbms_pkg::in_t it;
    it.action = act; it.pulse_override_ms = ovr; it.raw_reading = raw;
    pending_beats.push_back(it);
  endtask

  // ticks dominate so that pump runs and pulses play out
  function automatic pbms_pkg::in_t random_beat();
    pbms_pkg::in_t it;
    int            r;
    it.pulse_override_ms = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 40);
    it.raw_reading = 12'($urandom);
    r = $urandom_range(0, 99);
    if (r < 45)      it.action = pbms_pkg::ACT_TICK;
    else if (r < 56) it.action = pbms_pkg::ACT_ON;
    else if (r < 61) it.action = pbms_pkg::ACT_OFF;
    else if (r < 70) it.action = pbms_pkg::ACT_PULSE;
    else if (r < 88) it.action = pbms_pkg::ACT_SAMPLE;
    else if (r < 93) it.action = pbms_pkg::ACT_REFILL;
    else if (r < 97) it.action = pbms_pkg::ACT_NEWDAY;
    else             it.action = 3'd7;  // unused code
    return it;
  endfunction

  task automatic random_phase(int n);
    repeat (n / 2) pending_beats.push_back(random_beat());
    // sender holds off until every result so far is in
    wait (pending_beats.size() == 0 && !in_valid && expected_status.size() == 0);
    repeat (n - n / 2) pending_beats.push_back(random_beat());
    drain();
  endtask

  initial begin
    status_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: short pulses, tight budget
    configure(32'd3, 32'd20, 32'd3000, 32'd1200);
    push(pbms_pkg::ACT_SAMPLE, 32'd0, 12'd0);
    push(pbms_pkg::ACT_SAMPLE, 32'd0, 12'hFFF);
    push(pbms_pkg::ACT_SAMPLE, 32'd0, 12'd3000);
    push(pbms_pkg::ACT_NEWDAY, 32'd0, 12'd1200);
    push(pbms_pkg::ACT_ON, 32'd0, 12'd0);
    push(pbms_pkg::ACT_TICK, 32'd0, 12'd0);
    push(pbms_pkg::ACT_TICK, 32'd0, 12'd0);
    push(pbms_pkg::ACT_PULSE, 32'd0, 12'd0);      // restarts countdown on a running pump
    repeat (3) push(pbms_pkg::ACT_TICK, 32'd0, 12'd0);
    push(pbms_pkg::ACT_PULSE, 32'hFFFF_FFFF, 12'd0);  // over budget: timeout
    push(pbms_pkg::ACT_ON, 32'd0, 12'd0);         // ignored in timeout
    push(pbms_pkg::ACT_REFILL, 32'd0, 12'd0);
    push(pbms_pkg::ACT_ON, 32'd0, 12'd0);
    push(pbms_pkg::ACT_OFF, 32'd0, 12'd0);
    push(3'd7, 32'hFFFF_FFFF, 12'hFFF);
    drain();
    // zero pulse length and equal calibration
    configure(32'd0, 32'hFFFF_FFFF, 32'd2000, 32'd2000);
    push(pbms_pkg::ACT_PULSE, 32'd0, 12'd0);
    push(pbms_pkg::ACT_SAMPLE, 32'd0, 12'd2500);
    push(pbms_pkg::ACT_NEWDAY, 32'd0, 12'd0);
    drain();
    // capacity of one: the pump starts and, with no tick, runs on past the sample
    configure(32'd1, 32'd1, 32'd0, 32'd4095);
    push(pbms_pkg::ACT_ON, 32'd0, 12'd0);
    push(pbms_pkg::ACT_SAMPLE, 32'd0, 12'hFFF);
    drain();

    configure(32'd5, 32'd200, 32'd3000, 32'd1200);
    random_phase(250);
    configure(32'd1, 32'd1, 32'd0, 32'd4095);
    random_phase(200);
    no_idle = 1'b1;
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4095, 32'd0);
    random_phase(200);
    no_idle = 1'b0;
    configure(32'd7, 32'd500, 32'd2000, 32'd2000);
    random_phase(200);
    configure(32'd20, 32'h8000_0000, 32'd1000, 32'd3500);
    random_phase(200);
    configure(32'd12, 32'd90, 32'd3000, 32'd1200);
    random_phase(200);

    $display("covered %0d input beats and %0d result beats over 9 register settings",
             n_items, n_results);
    $display("actions, zero and over-budget pulses, equal calibration and stalls");
    if (errors == 0 && expected_status.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pbms_pkg.sv
rtl/pbms_div.sv
rtl/pbms_dp.sv
rtl/pbms_ctrl.sv
rtl/pump_budget_and_moisture_stats.sv
rtl/pbms_chk.sv
tb/sv/pump_budget_and_moisture_stats_test.sv
